// ===== sv/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

   localparam logic [16:0] ARENA_RESET = 17'd4096;
   localparam logic [16:0] ARENA_MAX   = 17'd65536;

   typedef struct packed {
      logic        func;
      logic [15:0] request_size;
      logic [15:0] free_address;
   } req_type;

   typedef struct packed {
      logic [15:0] payload_address;
      logic [1:0]  status;
      logic [16:0] used_bytes;
      logic [6:0]  block_count;
   } rsp_type;

   // one block descriptor as held in the table memory
   typedef struct packed {
      logic [15:0] start;
      logic [15:0] length;
      logic        is_free;
   } desc_type;

endpackage
`default_nettype wire

// ===== sv/ffba_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ffba_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== sv/first_fit_block_allocator_unit.sv =====
// Top level: sequencer walking the descriptor table for first-fit alloc and free.
//
//  channel  direction  handshake        payload
//  req      in         valid / ready    ffba_pkg::req_type
//  rsp      out        valid / ready    ffba_pkg::rsp_type
//  csr      in         write enable     arena size, 17 bits
//
// Work per item: the search reads each descriptor it visits through the single-port
// table memory, and a split that inserts or a merge that removes a descriptor moves
// each later entry one place, a read and then a write per entry moved.
// Reset (and a csr write) rebuilds the table by writing entry 0 only; no clearing pass.
// req_ready is low while an item is in work or its result waits on rsp.
`default_nettype none
module first_fit_block_allocator_unit #(
   parameter int MAX_BLOCKS         = 64,
   parameter int BLOCK_HEADER_BYTES = 16,
   parameter int POOL_HEADER_BYTES  = 12,
   parameter int MIN_PAYLOAD_BYTES  = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ffba_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ffba_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [16:0]       csr_data
);
   import ffba_pkg::*;

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int DW = $bits(desc_type);
   localparam logic [16:0] HDR  = 17'(BLOCK_HEADER_BYTES);
   localparam logic [16:0] POOL = 17'(POOL_HEADER_BYTES);
   localparam logic [16:0] MIN_ARENA =
      17'(POOL_HEADER_BYTES + BLOCK_HEADER_BYTES + MIN_PAYLOAD_BYTES);
   localparam logic [16:0] SPLIT_LIM = 17'(BLOCK_HEADER_BYTES + MIN_PAYLOAD_BYTES);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_CHK, ST_SH_RD, ST_SH_WR, ST_INS,
      ST_F_PREV, ST_F_NEXT, ST_F_NCHK, ST_RM_RD, ST_RM_WR, ST_DONE
   } state_type;

   state_type     state_ff;
   req_type       req_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;
   logic [CW-1:0] count_ff;
   logic [16:0]   used_ff;
   logic [CW-1:0] idx_ff;      // current search entry
   logic [CW-1:0] mv_ff;       // shift / remove cursor
   desc_type      cur_ff;      // descriptor found
   desc_type      prv_ff;      // previous descriptor seen
   logic          prv_ok_ff;
   logic          merged_ff;   // already merged with predecessor
   logic          tail_ff;     // further successor merge pending check

   logic          we;
   logic [IW-1:0] wa, ra;
   desc_type      wd, rd;
   logic [DW-1:0] rd_bits;
   desc_type      take_desc;   // block handed out, full length until split
   desc_type      free_desc;   // freed block, folded into a free predecessor

   ffba_ram #(.WIDTH(DW), .DEPTH(MAX_BLOCKS)) u_table (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd_bits));
   assign rd = desc_type'(rd_bits);

   always_comb begin
      take_desc = rd;
      take_desc.is_free = 1'b0;
      free_desc = rd;
      free_desc.is_free = 1'b1;
      if (prv_ok_ff && prv_ff.is_free) begin
         free_desc.start  = prv_ff.start;
         free_desc.length = prv_ff.length + rd.length + 16'(BLOCK_HEADER_BYTES);
      end
   end

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff && !csr_write;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic [16:0] arena_sat;
   assign arena_sat = (csr_data > ARENA_MAX) ? ARENA_MAX : csr_data;

   logic [16:0] remain;
   assign remain = {1'b0, rd.length} - {1'b0, req_ff.request_size};

   // memory port control
   always_comb begin
      we = 1'b0;
      wa = idx_ff[IW-1:0];
      wd = cur_ff;
      ra = idx_ff[IW-1:0];
      case (state_ff)
         ST_SH_RD: ra = IW'(mv_ff - 1'b1);
         ST_RM_RD: ra = IW'(mv_ff + 1'b1);
         ST_F_NEXT: ra = IW'(idx_ff + 1'b1);
         default: ;
      endcase
      if (reset || csr_write) begin
         we = 1'b1;
         wa = '0;
         wd.start   = 16'(POOL_HEADER_BYTES);
         wd.length  = reset ? 16'(ARENA_RESET - POOL - HDR) : 16'(arena_sat - POOL - HDR);
         wd.is_free = 1'b1;
      end else begin
         case (state_ff)
            ST_SH_WR: begin
               we = 1'b1; wa = mv_ff[IW-1:0]; wd = rd;
            end
            ST_RM_WR: begin
               we = 1'b1; wa = mv_ff[IW-1:0]; wd = rd;
            end
            ST_INS: begin
               we = 1'b1; wa = IW'(idx_ff + 1'b1);
               wd.start   = cur_ff.start + 16'(BLOCK_HEADER_BYTES) + req_ff.request_size;
               wd.length  = cur_ff.length - req_ff.request_size - 16'(BLOCK_HEADER_BYTES);
               wd.is_free = 1'b1;
            end
            ST_F_PREV: begin
               we = 1'b1; wa = idx_ff[IW-1:0]; wd = cur_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= CW'(1);
         used_ff      <= POOL + HDR;
      end else if (csr_write) begin
         state_ff <= ST_IDLE;
         if (arena_sat < MIN_ARENA) begin
            count_ff <= '0;
            used_ff  <= '0;
         end else begin
            count_ff <= CW'(1);
            used_ff  <= POOL + HDR;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req_valid && req_ready) begin
               req_ff    <= req_data;
               idx_ff    <= '0;
               prv_ok_ff <= 1'b0;
               merged_ff <= 1'b0;
               tail_ff   <= 1'b0;
               rsp_ff <= '{payload_address: '0,
                           status: (req_data.func == FUNC_ALLOC) ? STATUS_NO_FIT
                                                                 : STATUS_BAD_FREE,
                           used_bytes: '0, block_count: '0};
               state_ff <= ST_RD;
            end
            ST_RD: state_ff <= (idx_ff < count_ff) ? ST_CHK : ST_DONE;
            ST_CHK: begin
               if (req_ff.func == FUNC_ALLOC) begin
                  if (rd.is_free && rd.length >= req_ff.request_size) begin
                     rsp_ff <= '{payload_address: rd.start + 16'(BLOCK_HEADER_BYTES),
                                 status: STATUS_OK, used_bytes: '0, block_count: '0};
                     cur_ff <= take_desc;
                     if (remain > SPLIT_LIM && count_ff < CNT_MAX) begin
                        used_ff  <= used_ff + HDR + {1'b0, req_ff.request_size};
                        count_ff <= count_ff + 1'b1;
                        mv_ff    <= count_ff;
                        state_ff <= ST_SH_RD;
                     end else begin
                        used_ff  <= used_ff + {1'b0, rd.length};
                        state_ff <= ST_F_PREV;   // writes cur_ff back
                        tail_ff  <= 1'b0;
                     end
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= ST_RD;
                  end
               end else begin
                  if (!rd.is_free && (rd.start + 16'(BLOCK_HEADER_BYTES)) ==
                      req_ff.free_address) begin
                     rsp_ff.status <= STATUS_OK;
                     used_ff <= used_ff - {1'b0, rd.length};
                     cur_ff <= free_desc;
                     tail_ff <= 1'b1;
                     if (prv_ok_ff && prv_ff.is_free) begin
                        // fold into predecessor
                        idx_ff <= idx_ff - 1'b1;
                        merged_ff <= 1'b1;
                     end
                     state_ff <= ST_F_PREV;
                  end else begin
                     prv_ff <= rd;
                     prv_ok_ff <= 1'b1;
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= ST_RD;
                  end
               end
            end
            ST_SH_RD: state_ff <= (mv_ff > idx_ff + 1'b1) ? ST_SH_WR : ST_INS;
            ST_SH_WR: begin
               mv_ff <= mv_ff - 1'b1;
               state_ff <= ST_SH_RD;
            end
            ST_INS: begin
               // remainder written now, so the taken block can shrink
               cur_ff.length <= req_ff.request_size;
               state_ff <= ST_F_PREV;
            end
            ST_F_PREV: begin
               // cur_ff written here; alloc path ends, free looks ahead
               if (!tail_ff) state_ff <= ST_DONE;
               else if (merged_ff) begin
                  // remove entry idx+1 (the freed block) first
                  mv_ff <= idx_ff + 1'b1;
                  count_ff <= count_ff - 1'b1;
                  used_ff <= used_ff - HDR;
                  merged_ff <= 1'b0;
                  state_ff <= ST_RM_RD;
               end else state_ff <= ST_F_NEXT;
            end
            ST_F_NEXT: state_ff <= ST_F_NCHK;
            ST_F_NCHK: begin
               tail_ff <= 1'b0;
               if (idx_ff + 1'b1 < count_ff && rd.is_free) begin
                  cur_ff.length <= cur_ff.length + rd.length + 16'(BLOCK_HEADER_BYTES);
                  mv_ff <= idx_ff + 1'b1;
                  count_ff <= count_ff - 1'b1;
                  used_ff <= used_ff - HDR;
                  state_ff <= ST_RM_RD;
               end else state_ff <= ST_DONE;
            end
            ST_RM_RD: state_ff <= (mv_ff < count_ff) ? ST_RM_WR : ST_F_PREV;
            ST_RM_WR: begin
               mv_ff <= mv_ff + 1'b1;
               state_ff <= ST_RM_RD;
            end
            ST_DONE: begin
               rsp_ff <= '{payload_address: rsp_ff.payload_address,
                           status: rsp_ff.status,
                           used_bytes: used_ff,
                           block_count: 7'(count_ff)};
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench for the first-fit block allocator unit.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import ffba_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int HDR_BYTES    = 16;
   localparam int POOL_BYTES   = 12;
   localparam int MIN_PAYLOAD  = 32;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_data = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_write = 1'b0;
   logic [16:0]   csr_data = '0;

   first_fit_block_allocator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // shadow of the allocator state
   int         arena_size;
   int         blk_start [TABLE_DEPTH];
   int         blk_len   [TABLE_DEPTH];
   bit         blk_free  [TABLE_DEPTH];
   int         blk_count;
   int         used_total;
   int         live_payloads[$];
   int         last_freed;
   rsp_type    pending_rsp[$];
   int         error_count = 0;
   int         snd_idle_pct = 0;
   int         rcv_idle_pct = 0;

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   function automatic void rebuild_table();
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         blk_start[k] = 0;
         blk_len[k]   = 0;
         blk_free[k]  = 1'b0;
      end
      live_payloads.delete();
      if (arena_size < POOL_BYTES + HDR_BYTES + MIN_PAYLOAD) begin
         blk_count  = 0;
         used_total = 0;
      end else begin
         blk_start[0] = POOL_BYTES;
         blk_len[0]   = arena_size - POOL_BYTES - HDR_BYTES;
         blk_free[0]  = 1'b1;
         blk_count    = 1;
         used_total   = POOL_BYTES + HDR_BYTES;
      end
   endfunction

   function automatic void absorb_next(int k);
      blk_len[k] += blk_len[k + 1] + HDR_BYTES;
      for (int j = k + 1; j + 1 < blk_count; j++) begin
         blk_start[j] = blk_start[j + 1];
         blk_len[j]   = blk_len[j + 1];
         blk_free[j]  = blk_free[j + 1];
      end
      blk_count--;
      used_total -= HDR_BYTES;
   endfunction

   function automatic rsp_type predict_allocator(req_type it);
      rsp_type r;
      int      want;
      int      i;
      r = '0;
      want = int'(it.request_size);
      if (it.func == FUNC_ALLOC) begin
         r.status = STATUS_NO_FIT;
         for (i = 0; i < blk_count; i++) begin
            if (!blk_free[i] || blk_len[i] < want) continue;
            if (blk_len[i] - want > HDR_BYTES + MIN_PAYLOAD && blk_count < TABLE_DEPTH) begin
               for (int j = blk_count; j > i + 1; j--) begin
                  blk_start[j] = blk_start[j - 1];
                  blk_len[j]   = blk_len[j - 1];
                  blk_free[j]  = blk_free[j - 1];
               end
               blk_start[i + 1] = blk_start[i] + HDR_BYTES + want;
               blk_len[i + 1]   = blk_len[i] - want - HDR_BYTES;
               blk_free[i + 1]  = 1'b1;
               blk_len[i]       = want;
               blk_count++;
               used_total += HDR_BYTES;
            end
            blk_free[i] = 1'b0;
            used_total += blk_len[i];
            r.payload_address = 16'(blk_start[i] + HDR_BYTES);
            r.status = STATUS_OK;
            live_payloads.push_back(blk_start[i] + HDR_BYTES);
            break;
         end
      end else begin
         r.status = STATUS_BAD_FREE;
         for (i = 0; i < blk_count; i++) begin
            if (blk_free[i] || blk_start[i] + HDR_BYTES != int'(it.free_address)) continue;
            blk_free[i] = 1'b1;
            used_total -= blk_len[i];
            if (i > 0 && blk_free[i - 1]) begin
               absorb_next(i - 1);
               i--;
            end
            if (i + 1 < blk_count && blk_free[i + 1]) absorb_next(i);
            r.status = STATUS_OK;
            foreach (live_payloads[k])
               if (live_payloads[k] == int'(it.free_address)) begin
                  live_payloads.delete(k);
                  break;
               end
            last_freed = int'(it.free_address);
            break;
         end
      end
      r.used_bytes  = 17'(used_total);
      r.block_count = 7'(blk_count);
      return r;
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result with nothing pending", 1, 0);
         end else begin
            rsp_type want;
            want = pending_rsp.pop_front();
            if (rsp_data.payload_address !== want.payload_address)
               report_mismatch("payload_address", int'(rsp_data.payload_address),
                               int'(want.payload_address));
            if (rsp_data.status !== want.status)
               report_mismatch("status", int'(rsp_data.status), int'(want.status));
            if (rsp_data.used_bytes !== want.used_bytes)
               report_mismatch("used_bytes", int'(rsp_data.used_bytes),
                               int'(want.used_bytes));
            if (rsp_data.block_count !== want.block_count)
               report_mismatch("block_count", int'(rsp_data.block_count),
                               int'(want.block_count));
         end
      end
      rsp_ready <= (rcv_idle_pct == 0) || ($urandom_range(99) >= rcv_idle_pct);
   end

   // valid stays up between back-to-back items; only lowered for a gap or a drain
   task automatic send_item(req_type it);
      if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(predict_allocator(it));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_arena(int value);
      drain_results();
      csr_write <= 1'b1;
      csr_data  <= 17'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      arena_size = (value > int'(ARENA_MAX)) ? int'(ARENA_MAX) : value;
      rebuild_table();
      @(posedge clock);
   endtask

   task automatic send_alloc(int bytes);
      req_type it;
      it = '0;
      it.func = FUNC_ALLOC;
      it.request_size = 16'(bytes);
      it.free_address = 16'($urandom);
      send_item(it);
   endtask

   task automatic send_free(int where);
      req_type it;
      it = '0;
      it.func = FUNC_FREE;
      it.request_size = 16'($urandom);
      it.free_address = 16'(where);
      send_item(it);
   endtask

   task automatic test_directed_ops();
      send_alloc(0);                      // zero size, splits
      send_alloc(100);
      send_alloc(200);
      send_alloc(16'hFFFF);               // no fit
      send_free(0);                       // unknown offset
      send_free(16'hFFFF);
      send_free(live_payloads[1]);
      send_free(last_freed);              // double free
      send_free(live_payloads[0]);        // merges with free successor
      send_free(live_payloads[0]);        // merges both sides
      send_alloc(4068);                   // whole arena, no split
      send_alloc(1);
      send_free(live_payloads[0]);
      send_alloc(4068 - 48);              // remainder exactly header + minimum
      send_alloc(10);
      drain_results();
   endtask

   task automatic test_arena_edges();
      write_arena(0);
      send_alloc(0);
      send_free(POOL_BYTES + HDR_BYTES);
      write_arena(POOL_BYTES + HDR_BYTES + MIN_PAYLOAD - 1);
      send_alloc(0);
      write_arena(POOL_BYTES + HDR_BYTES + MIN_PAYLOAD);
      send_alloc(33);
      send_alloc(32);
      send_alloc(0);
      send_free(live_payloads[0]);
      write_arena(17'h1FFFF);             // saturates
      send_alloc(65508);
      send_alloc(0);
      send_free(live_payloads[0]);
      write_arena(int'(ARENA_MAX));
      send_alloc(65508);
      drain_results();
   endtask

   // mostly allocs and frees of live blocks, some noise
   task automatic test_random_traffic(int count, int s_pct, int r_pct, bit pause_once);
      int pick;
      int bytes;
      snd_idle_pct = s_pct;
      rcv_idle_pct = r_pct;
      for (int n = 0; n < count; n++) begin
         if (pause_once && n == count / 2) drain_results();
         pick = $urandom_range(99);
         if (pick < 55 || (pick < 90 && live_payloads.size() == 0)) begin
            pick = $urandom_range(99);
            if (pick < 55)      bytes = $urandom_range(64);
            else if (pick < 80) bytes = $urandom_range(400);
            else if (pick < 93) bytes = $urandom_range(arena_size);
            else                bytes = $urandom_range(16'hFFFF);
            send_alloc(bytes);
         end else if (pick < 90) begin
            send_free(live_payloads[$urandom_range(live_payloads.size() - 1)]);
         end else if (pick < 95) begin
            send_free(last_freed);
         end else begin
            send_free($urandom_range(16'hFFFF));
         end
      end
      drain_results();
   endtask

   initial begin
      arena_size = int'(ARENA_RESET);
      rebuild_table();
      last_freed = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_ops();
      test_arena_edges();
      write_arena(int'(ARENA_RESET));
      test_random_traffic(420, 25, 71, 1'b1);
      write_arena(int'(ARENA_MAX));
      test_random_traffic(420, 71, 25, 1'b0);
      write_arena($urandom_range(200, 3000));
      test_random_traffic(230, 0, 0, 1'b0);
      write_arena(1000);
      test_random_traffic(230, 0, 0, 1'b0);
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
